@@ rtl/tte_pkg.sv @@
// tte_pkg: constants shared by the tap tempo estimator.
// Holds register indexes, tempo mode codes and fixed arithmetic constants.
// No dependencies.
package tte_pkg;

  localparam int unsigned MaxIntervalsDefault = 16;

  // Field widths fixed by the interface
  localparam int unsigned TimeW  = 32;
  localparam int unsigned TempoW = 32;
  localparam int unsigned MeanW  = 13;
  localparam int unsigned UsedW  = 5;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned WinW   = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  localparam int unsigned FracW    = 16;
  localparam int unsigned GapLimit = 5000;
  localparam int unsigned MsPerSec = 1000;
  localparam int unsigned MsPerMin = 60000;
  localparam int unsigned MaxGap   = GapLimit - 1;

  localparam logic [WinW-1:0] WindowReset = 5'd4;

  // Register index, taken from paddr[2]
  localparam logic REG_TEMPO_MODE = 1'b0;
  localparam logic REG_WINDOW     = 1'b1;

  localparam logic [ModeW-1:0] MODE_FREQ   = 2'd0;
  localparam logic [ModeW-1:0] MODE_PERIOD = 2'd1;
  localparam logic [ModeW-1:0] MODE_BPM    = 2'd2;

endpackage

@@ rtl/tap_tempo_estimator.sv @@
// tap_tempo_estimator: tap tempo by moving average over a ring of tap times.
// Holds the tap history memory, a shared bit-serial restoring divider and an
// APB register port. Depends on tte_pkg.
//
// Channel   Dir  Handshake                      Payload
// tap       in   tap_valid_i / tap_ready_o      tap_time_ms_i
// result    out  result_valid_o / result_ready_i tempo_updated_o, tempo_value_o,
//                                                mean_interval_ms_o, intervals_used_o
// config    in   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A tap that restarts the history or leaves fewer than two taps goes straight to the final state.
// A tap that updates the tempo reads the oldest tap time, forms the span, then divides with
// one divider shared for the mean (SPAN_W bit steps) and the tempo (QW steps);
// tempo mode three skips the tempo steps.
// Reset empties the history; memory contents are never read before written.
// A waiting result sits in the output register while the next tap is taken;
// a new result waits in the final state until that register is free.
module tap_tempo_estimator #(
  parameter int unsigned MAX_INTERVALS = tte_pkg::MaxIntervalsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tap_valid_i,
  output logic                         tap_ready_o,
  input  logic [tte_pkg::TimeW-1:0]    tap_time_ms_i,
  output logic                         result_valid_o,
  input  logic                         result_ready_i,
  output logic                         tempo_updated_o,
  output logic [tte_pkg::TempoW-1:0]   tempo_value_o,
  output logic [tte_pkg::MeanW-1:0]    mean_interval_ms_o,
  output logic [tte_pkg::UsedW-1:0]    intervals_used_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tte_pkg::AddrW-1:0]    paddr,
  input  logic [tte_pkg::DataW-1:0]    pwdata,
  output logic [tte_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  localparam int unsigned DEPTH  = MAX_INTERVALS + 1;
  localparam int unsigned HEAD_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned SPAN_W = $clog2(tte_pkg::MaxGap * MAX_INTERVALS + 1);
  localparam int unsigned P1K_W  = $clog2(tte_pkg::MsPerSec * MAX_INTERVALS + 1);
  localparam int unsigned P60_W  = $clog2(tte_pkg::MsPerMin * MAX_INTERVALS + 1);
  localparam int unsigned DVS_W  = (SPAN_W > P1K_W) ? SPAN_W : P1K_W;
  localparam int unsigned NUM_B  = (P60_W > SPAN_W) ? P60_W : SPAN_W;
  localparam int unsigned NUM_W  = NUM_B + tte_pkg::FracW;
  localparam int unsigned QW     = (NUM_W > tte_pkg::TempoW) ? NUM_W : tte_pkg::TempoW + 1;
  localparam int unsigned DC_W   = $clog2(QW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SPAN = 3'd2;
  localparam logic [2:0] S_DIVM = 3'd3;
  localparam logic [2:0] S_DIVT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Configuration registers
  logic [tte_pkg::ModeW-1:0] mode_q;
  logic [tte_pkg::WinW-1:0]  win_q;
  logic                      cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (paddr[2] == tte_pkg::REG_TEMPO_MODE) ? tte_pkg::DataW'(mode_q)
                                                         : tte_pkg::DataW'(win_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tte_pkg::MODE_FREQ;
      win_q  <= tte_pkg::WindowReset;
    end else if (cfg_we) begin
      unique case (paddr[2])
        tte_pkg::REG_TEMPO_MODE: mode_q <= pwdata[tte_pkg::ModeW-1:0];
        tte_pkg::REG_WINDOW:     win_q  <= pwdata[tte_pkg::WinW-1:0];
        default: ;
      endcase
    end
  end

  // Control and history state
  logic [2:0]              state_q, state_d;
  logic [HEAD_W-1:0]       head_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [tte_pkg::TimeW-1:0] prev_q;
  logic [HEAD_W-1:0]       oldest_q;
  logic [tte_pkg::TimeW-1:0] rd_q;
  logic [SPAN_W-1:0]       span_q;
  logic [P1K_W-1:0]        p1k_q;
  logic [P60_W-1:0]        p60_q;

  // Result staging and output register
  logic                        upd_q;
  logic [tte_pkg::TempoW-1:0]  tempo_q;
  logic [tte_pkg::MeanW-1:0]   mean_q;
  logic [CNT_W-1:0]            n_q;

  // Divider
  logic [QW-1:0]     quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DC_W-1:0]   dcnt_q;
  logic [DVS_W:0]    trial;
  logic              q_bit;
  logic [DVS_W-1:0]  rem_nx;

  logic [tte_pkg::TimeW-1:0] hist_mem [DEPTH];

  logic                       tap_acc;
  logic                       out_free;
  logic [tte_pkg::TimeW-1:0]  gap;
  logic                       restart;
  logic [HEAD_W-1:0]          head_nx;
  logic [CNT_W-1:0]           cnt_inc;
  logic [CNT_W-1:0]           keep;
  logic [CNT_W-1:0]           cnt_new;
  logic [SUM_W-1:0]           head_ext;
  logic [HEAD_W-1:0]          oldest_nx;
  logic                       win_full;
  logic [tte_pkg::TimeW-1:0]  span_w;
  logic [NUM_W-1:0]           tnum;
  logic [DVS_W-1:0]           tdvs;

  assign tap_ready_o = (state_q == S_IDLE);
  assign tap_acc     = tap_valid_i & tap_ready_o;
  assign out_free    = ~result_valid_o | result_ready_i;

  assign gap     = tap_time_ms_i - prev_q;
  assign restart = (gap == '0) || (gap >= tte_pkg::TimeW'(tte_pkg::GapLimit));
  assign head_nx = (head_q == HEAD_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign cnt_inc = (cnt_q < CNT_W'(DEPTH)) ? cnt_q + 1'b1 : cnt_q;

  // Window of zero or beyond the ring means the whole ring
  assign win_full = (win_q == '0) || (32'(win_q) > 32'(MAX_INTERVALS));
  assign keep     = win_full ? CNT_W'(DEPTH) : CNT_W'(win_q) + 1'b1;
  assign cnt_new  = (cnt_inc > keep) ? keep : cnt_inc;

  assign head_ext  = SUM_W'(head_nx);
  assign oldest_nx = (head_ext >= SUM_W'(cnt_new))
                   ? HEAD_W'(head_ext - SUM_W'(cnt_new))
                   : HEAD_W'(head_ext + SUM_W'(DEPTH) - SUM_W'(cnt_new));

  // prev_q already holds the newest tap time
  assign span_w = prev_q - rd_q;

  always_comb begin
    unique case (mode_q)
      tte_pkg::MODE_PERIOD: begin
        tnum = NUM_W'({span_q, tte_pkg::FracW'(0)});
        tdvs = DVS_W'(p1k_q);
      end
      tte_pkg::MODE_BPM: begin
        tnum = NUM_W'({p60_q, tte_pkg::FracW'(0)});
        tdvs = DVS_W'(span_q);
      end
      default: begin
        tnum = NUM_W'({p1k_q, tte_pkg::FracW'(0)});
        tdvs = DVS_W'(span_q);
      end
    endcase
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial  = {rem_q, quo_q[QW-1]};
  assign q_bit  = (trial >= {1'b0, dvs_q});
  assign rem_nx = q_bit ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (tap_acc) state_d = (!restart && cnt_new >= CNT_W'(2)) ? S_READ : S_DONE;
      S_READ: state_d = S_SPAN;
      S_SPAN: state_d = S_DIVM;
      S_DIVM: begin
        if (dcnt_q == '0) state_d = (mode_q == tte_pkg::MODE_FREQ ||
                                     mode_q == tte_pkg::MODE_PERIOD ||
                                     mode_q == tte_pkg::MODE_BPM) ? S_DIVT : S_DONE;
      end
      S_DIVT: if (dcnt_q == '0) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      head_q         <= '0;
      cnt_q          <= '0;
      prev_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tap_acc) begin
        prev_q <= tap_time_ms_i;
        if (restart) begin
          head_q <= HEAD_W'(1);
          cnt_q  <= CNT_W'(1);
        end else begin
          head_q <= head_nx;
          cnt_q  <= cnt_new;
        end
      end
      if (state_q == S_DONE && out_free) begin
        result_valid_o <= 1'b1;
      end else if (result_ready_i) begin
        result_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_acc) begin
      hist_mem[restart ? '0 : head_q] <= tap_time_ms_i;
    end
    if (state_q == S_READ) begin
      rd_q <= hist_mem[oldest_q];
    end
  end

  // Datapath and staging registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        oldest_q <= oldest_nx;
        upd_q    <= 1'b0;
        tempo_q  <= '0;
        mean_q   <= '0;
        n_q      <= '0;
        if (tap_acc && !restart && cnt_new >= CNT_W'(2)) begin
          upd_q <= 1'b1;
          n_q   <= cnt_new - 1'b1;
        end
      end
      S_READ: begin
        p1k_q <= P1K_W'(32'(n_q) * 32'(tte_pkg::MsPerSec));
        p60_q <= P60_W'(32'(n_q) * 32'(tte_pkg::MsPerMin));
      end
      S_SPAN: begin
        span_q <= SPAN_W'(span_w);
        quo_q  <= QW'(SPAN_W'(span_w)) << (QW - SPAN_W);
        rem_q  <= '0;
        dvs_q  <= DVS_W'(n_q);
        dcnt_q <= DC_W'(SPAN_W);
      end
      S_DIVM: begin
        if (dcnt_q != '0) begin
          quo_q  <= {quo_q[QW-2:0], q_bit};
          rem_q  <= rem_nx;
          dcnt_q <= dcnt_q - 1'b1;
        end else begin
          mean_q <= quo_q[tte_pkg::MeanW-1:0];
          quo_q  <= QW'(tnum);
          rem_q  <= '0;
          dvs_q  <= tdvs;
          dcnt_q <= DC_W'(QW);
        end
      end
      S_DIVT: begin
        if (dcnt_q != '0) begin
          quo_q  <= {quo_q[QW-2:0], q_bit};
          rem_q  <= rem_nx;
          dcnt_q <= dcnt_q - 1'b1;
        end else begin
          tempo_q <= (|quo_q[QW-1:tte_pkg::TempoW]) ? '1 : quo_q[tte_pkg::TempoW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      tempo_updated_o    <= upd_q;
      tempo_value_o      <= tempo_q;
      mean_interval_ms_o <= mean_q;
      intervals_used_o   <= tte_pkg::UsedW'(n_q);
    end
  end

`ifndef SYNTHESIS
  a_ring_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_W'(DEPTH)) && (head_q < HEAD_W'(DEPTH)))
    else $error("history ring head or count out of range");

  a_busy_after_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_acc |=> !tap_ready_o)
    else $error("tap taken while previous tap still in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && result_valid_o && !result_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped while output register was full");

  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVM || state_q == S_DIVT) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> (mean_interval_ms_o < tte_pkg::MeanW'(tte_pkg::GapLimit)))
    else $error("mean interval beyond gap limit");
`endif

endmodule
